### src/calibration_frame_receiver_defines.svh
// Assertion macros used by the checker file.
`ifndef CALIBRATION_FRAME_RECEIVER_DEFINES_SVH
`define CALIBRATION_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cfr_pkg.sv
package cfr_pkg;

  localparam int FRAME_LEN     = 68;
  localparam int ADDR_W        = 7;
  localparam int PAYLOAD_OFS   = 2;
  localparam int PAYLOAD_WORDS = 16;

  localparam logic [7:0]  SYNC_FIRST  = 8'd117;
  localparam logic [7:0]  SYNC_SECOND = 8'd84;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_LEN - 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_DECIDE  = 6'b000100,
    ST_SHIFT   = 6'b001000,
    ST_EMIT    = 6'b010000,
    ST_EMIT_RD = 6'b100000
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic scan_start;
    logic scan_mode;
    logic shift_start;
    logic shift_mode;
    logic tail_fill;
    logic emit_init;
    logic emit_start;
    logic emit_mode;
  } cmd_t;

  typedef struct packed {
    logic frame_full;
    logic sweep_done;
    logic crc_ok;
    logic pair_found;
    logic word_free;
    logic last_k;
  } status_t;

  // One byte of CRC-16, reflected, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/cfr_datapath.sv
module cfr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  cfr_pkg::cmd_t                cmd,
  input  logic [7:0]                   rx_byte,
  output cfr_pkg::status_t             sts,
  output logic                         word_valid,
  input  logic                         word_ready,
  output logic [3:0]                   word_index,
  output logic [31:0]                  payload_word,
  output logic                         last_word
);

  logic [7:0] mem [cfr_pkg::FRAME_LEN];

  logic [cfr_pkg::ADDR_W-1:0] fill;
  logic                       active;
  logic [cfr_pkg::ADDR_W-1:0] ptr;
  logic [cfr_pkg::ADDR_W-1:0] stop;
  logic                       dvld;
  logic [cfr_pkg::ADDR_W-1:0] dpos;
  logic [7:0]                 rd_data;
  logic [15:0]                crc;
  logic [7:0]                 prev;
  logic                       found;
  logic [cfr_pkg::ADDR_W-1:0] fidx;
  logic                       tail_sync;
  logic [cfr_pkg::ADDR_W-1:0] wbase;
  logic [3:0]                 k;
  logic [31:0]                word_sh;
  logic [31:0]                word_next;

  logic store_ok;
  logic sweep_done;
  logic sweep_start;
  logic [cfr_pkg::ADDR_W-1:0] start_addr;
  logic [cfr_pkg::ADDR_W-1:0] stop_addr;

  assign store_ok = (fill == '0) ? (rx_byte == cfr_pkg::SYNC_FIRST) :
                    (fill == cfr_pkg::ADDR_W'(1)) ? (rx_byte == cfr_pkg::SYNC_SECOND) : 1'b1;
  assign sweep_done = dvld && (dpos == stop);
  assign word_next  = {rd_data, word_sh[31:8]};
  assign sweep_start = cmd.scan_start || cmd.shift_start || cmd.emit_start;

  always_comb begin
    priority if (cmd.scan_start) begin
      start_addr = '0;
      stop_addr  = cfr_pkg::LAST_ADDR;
    end else if (cmd.shift_start) begin
      start_addr = fidx;
      stop_addr  = cfr_pkg::LAST_ADDR;
    end else begin
      start_addr = wbase;
      stop_addr  = wbase + cfr_pkg::ADDR_W'(3);
    end
  end

  assign sts.frame_full = (fill == cfr_pkg::LAST_ADDR);
  assign sts.sweep_done = sweep_done;
  assign sts.crc_ok     = (crc == '0);
  assign sts.pair_found = found;
  assign sts.word_free  = !word_valid || word_ready;
  assign sts.last_k     = (k == 4'(cfr_pkg::PAYLOAD_WORDS - 1));

  // Frame memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && store_ok) begin
      mem[fill] <= rx_byte;
    end else if (cmd.shift_mode && dvld) begin
      mem[dpos - fidx] <= rd_data;
    end
    if (active) begin
      rd_data <= mem[ptr];
    end
  end

  // Read sweep, fill count and pair-found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      active <= 1'b0;
      dvld   <= 1'b0;
      found  <= 1'b0;
    end else begin
      dvld <= active;
      if (active) begin
        dpos <= ptr;
        if (ptr == stop) begin
          active <= 1'b0;
        end else begin
          ptr <= ptr + cfr_pkg::ADDR_W'(1);
        end
      end
      if (sweep_start) begin
        active <= 1'b1;
        ptr    <= start_addr;
        stop   <= stop_addr;
      end

      if (cmd.take_byte) begin
        if (store_ok) begin
          fill <= fill + cfr_pkg::ADDR_W'(1);
        end else if (fill == cfr_pkg::ADDR_W'(1)) begin
          fill <= '0;
        end
      end else if (cmd.shift_start) begin
        fill <= cfr_pkg::ADDR_W'(cfr_pkg::FRAME_LEN) - fidx;
      end else if (cmd.tail_fill) begin
        fill <= tail_sync ? cfr_pkg::ADDR_W'(1) : '0;
      end else if (cmd.emit_init) begin
        fill <= '0;
      end

      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (cmd.scan_mode && dvld && !found && dpos >= cfr_pkg::ADDR_W'(3) &&
                   prev == cfr_pkg::SYNC_FIRST && rd_data == cfr_pkg::SYNC_SECOND) begin
        found <= 1'b1;
      end
    end
  end

  // CRC, pair search and word assembly.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      crc <= cfr_pkg::CRC_INIT;
    end else if (cmd.scan_mode && dvld) begin
      crc       <= cfr_pkg::crc_byte(crc, rd_data);
      prev      <= rd_data;
      tail_sync <= (rd_data == cfr_pkg::SYNC_FIRST);
      if (!found && dpos >= cfr_pkg::ADDR_W'(3) &&
          prev == cfr_pkg::SYNC_FIRST && rd_data == cfr_pkg::SYNC_SECOND) begin
        fidx <= dpos - cfr_pkg::ADDR_W'(1);
      end
    end
    if (cmd.emit_init) begin
      wbase <= cfr_pkg::ADDR_W'(cfr_pkg::PAYLOAD_OFS);
      k     <= '0;
    end else if (cmd.emit_mode && sweep_done) begin
      wbase <= wbase + cfr_pkg::ADDR_W'(4);
      k     <= k + 4'd1;
    end
    if (cmd.emit_mode && dvld) begin
      word_sh <= word_next;
    end
    if (cmd.emit_mode && sweep_done) begin
      payload_word <= word_next;
      word_index   <= k;
      last_word    <= sts.last_k;
    end
  end

  // Output register handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (cmd.emit_mode && sweep_done) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

endmodule

### src/cfr_ctrl.sv
module cfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  cfr_pkg::status_t sts,
  output cfr_pkg::cmd_t    cmd
);

  cfr_pkg::state_t state;
  cfr_pkg::state_t state_next;

  assign byte_ready = (state == cfr_pkg::ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      cfr_pkg::ST_IDLE: begin
        cmd.take_byte = byte_valid;
        if (byte_valid && sts.frame_full) begin
          cmd.scan_start = 1'b1;
          state_next     = cfr_pkg::ST_SCAN;
        end
      end
      cfr_pkg::ST_SCAN: begin
        cmd.scan_mode = 1'b1;
        if (sts.sweep_done) begin
          state_next = cfr_pkg::ST_DECIDE;
        end
      end
      cfr_pkg::ST_DECIDE: begin
        priority if (sts.crc_ok) begin
          cmd.emit_init = 1'b1;
          state_next    = cfr_pkg::ST_EMIT;
        end else if (sts.pair_found) begin
          cmd.shift_start = 1'b1;
          state_next      = cfr_pkg::ST_SHIFT;
        end else begin
          cmd.tail_fill = 1'b1;
          state_next    = cfr_pkg::ST_IDLE;
        end
      end
      cfr_pkg::ST_SHIFT: begin
        cmd.shift_mode = 1'b1;
        if (sts.sweep_done) begin
          state_next = cfr_pkg::ST_IDLE;
        end
      end
      cfr_pkg::ST_EMIT: begin
        if (sts.word_free) begin
          cmd.emit_start = 1'b1;
          state_next     = cfr_pkg::ST_EMIT_RD;
        end
      end
      cfr_pkg::ST_EMIT_RD: begin
        cmd.emit_mode = 1'b1;
        if (sts.sweep_done) begin
          state_next = sts.last_k ? cfr_pkg::ST_IDLE : cfr_pkg::ST_EMIT;
        end
      end
      default: begin
        state_next = cfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/calibration_frame_receiver.sv
// Framed packet receiver: takes serial bytes on the byte channel, hunts for
// the sync pair 117,84 and collects a 68-byte frame in a 68 x 8 memory. On
// the 68th byte it makes one read sweep over the memory that runs the CRC-16
// (reflected 0xA001, start 0xFFFF) and looks for a later sync pair at the
// same time; a zero residue means a good frame, and the 16 little-endian
// 32-bit payload words from byte 2 on come out on the word channel, the last
// one flagged. A bad frame with a later pair has the bytes from that pair on
// moved to the front; otherwise a trailing 117 is kept as a new start, or the
// buffer is emptied. A byte that does not complete a frame leaves the byte
// channel ready. The check sweep makes one memory read a cycle through the
// registered read port; then comes either a shift of the bytes from the pair
// on (one read and one write a cycle) or one four-byte read sweep per payload
// word, each held back while the word channel stalls. The byte channel is not
// ready during that work, and the last payload word may still wait in the
// output register while new bytes arrive.
module calibration_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  rx_byte,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [3:0]  word_index,
  output logic [31:0] payload_word,
  output logic        last_word
);

  // Commands from the controller, status back from the datapath.
  cfr_pkg::cmd_t    cmd;
  cfr_pkg::status_t sts;

  cfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Frame memory, CRC, sync search, shift and word assembly.
  cfr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .sts          (sts),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word_index   (word_index),
    .payload_word (payload_word),
    .last_word    (last_word)
  );

endmodule

### src/cfr_checker.sv
`include "calibration_frame_receiver_defines.svh"

module cfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_ready,
  input logic [7:0]  rx_byte,
  input logic        word_valid,
  input logic        word_ready,
  input logic [3:0]  word_index,
  input logic [31:0] payload_word,
  input logic        last_word
);

  // The flag marks exactly the final word position.
  `CFR_ASSERT_NOW(a_last_mark, word_valid, last_word == (&word_index), "last_word mismatch")

  // While a frame is still being delivered, no new byte is taken.
  `CFR_ASSERT_NEXT(a_busy_mid_frame, word_valid && word_ready && !last_word, !byte_ready,
    "byte channel ready in the middle of a frame")

  // A stalled word holds.
  `CFR_ASSERT_NEXT(a_word_hold, word_valid && !word_ready,
    word_valid && $stable(word_index) && $stable(payload_word) && $stable(last_word),
    "stalled word changed")

endmodule

bind calibration_frame_receiver cfr_checker u_cfr_checker (.*);

### tb/tb.sv
module tb;

  localparam int          FRAME_LEN     = cfr_pkg::FRAME_LEN;
  localparam int          PAYLOAD_OFS   = cfr_pkg::PAYLOAD_OFS;
  localparam int          PAYLOAD_WORDS = cfr_pkg::PAYLOAD_WORDS;
  localparam logic [7:0]  SYNC_FIRST    = cfr_pkg::SYNC_FIRST;
  localparam logic [7:0]  SYNC_SECOND   = cfr_pkg::SYNC_SECOND;
  localparam logic [15:0] CRC_POLY      = cfr_pkg::CRC_POLY;
  localparam logic [15:0] CRC_INIT      = cfr_pkg::CRC_INIT;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          HOLD_CYCLES  = 1500;
  localparam int          N_DIRECTED   = 12;
  localparam int unsigned RANDOM_BYTES = 24;

  typedef enum logic [2:0] {
    ROW_BYTE,
    ROW_NOISE,
    ROW_GOOD,
    ROW_CORRUPT,
    ROW_RESYNC,
    ROW_TAIL
  } row_kind_e;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_HALF,
    PACE_SPARSE
  } rx_pace_e;

  // val: byte value or payload fill; pos: sync offset or noise length.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  val;
    logic        rand_fill;
    logic [6:0]  pos;
    logic        typed;
    logic [31:0] word;
    logic        hold;
    logic        drain;
  } row_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] data;
    logic        last;
  } word_rec_t;

  // kind, val, rand_fill, pos, typed, word, hold, drain
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_BYTE,    8'h00,       1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    8'hFF,       1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    SYNC_SECOND, 1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    SYNC_FIRST,  1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    SYNC_FIRST,  1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    SYNC_SECOND, 1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    SYNC_FIRST,  1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    8'h00,       1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_RESYNC,  8'h00,       1'b0, 7'd2,  1'b0, 32'h0,        1'b1, 1'b0},
    '{ROW_TAIL,    8'h00,       1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b0},
    '{ROW_BYTE,    8'h00,       1'b0, 7'd0,  1'b0, 32'h0,        1'b0, 1'b1},
    '{ROW_NOISE,   8'h00,       1'b0, 7'd5,  1'b0, 32'h0,        1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        word_valid;
  logic        word_ready = 1'b0;
  logic [3:0]  word_index;
  logic [31:0] payload_word;
  logic        last_word;

  // predictor state
  logic [7:0]  held_bytes [FRAME_LEN];
  int          held_count = 0;

  logic [7:0]  frame_bytes [FRAME_LEN];
  word_rec_t   fresh_words [$];
  word_rec_t   pending_words [$];
  word_rec_t   got_word, want_word;

  bit          typed_on = 1'b0;
  logic [31:0] typed_word = '0;
  int          burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_reqs = 0;

  calibration_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .rx_byte      (rx_byte),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word_index   (word_index),
    .payload_word (payload_word),
    .last_word    (last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int n;
    c = crc ^ {8'h00, b};
    for (n = 0; n < 8; n++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // Advance the predictor by one accepted byte; payload words go to fresh_words.
  function automatic void absorb_byte(input logic [7:0] b);
    logic [15:0] crc;
    word_rec_t   rec;
    int          i, k, p;
    bit          found;
    if (held_count >= FRAME_LEN) begin
      held_count = 0;
      return;
    end
    if (held_count == 0 && b != SYNC_FIRST) return;
    if (held_count == 1 && b != SYNC_SECOND) begin
      held_count = 0;
      return;
    end
    held_bytes[held_count] = b;
    held_count++;
    if (held_count < FRAME_LEN) return;

    crc = CRC_INIT;
    for (i = 0; i < FRAME_LEN; i++) crc = crc16_step(crc, held_bytes[i]);

    if (crc == 16'h0000) begin
      for (k = 0; k < PAYLOAD_WORDS; k++) begin
        p = PAYLOAD_OFS + 4 * k;
        rec.idx  = 4'(k);
        rec.data = {held_bytes[p+3], held_bytes[p+2], held_bytes[p+1], held_bytes[p]};
        rec.last = (k == PAYLOAD_WORDS - 1);
        fresh_words.push_back(rec);
      end
      held_count = 0;
      return;
    end

    // bad frame: move the first later sync pair to the front
    found = 1'b0;
    for (p = 2; p < FRAME_LEN - 1 && !found; p++) begin
      if (held_bytes[p] == SYNC_FIRST && held_bytes[p+1] == SYNC_SECOND) begin
        held_count = FRAME_LEN - p;
        for (i = 0; i < held_count; i++) held_bytes[i] = held_bytes[i+p];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (held_bytes[FRAME_LEN-1] == SYNC_FIRST) begin
        held_bytes[0] = SYNC_FIRST;
        held_count = 1;
      end else begin
        held_count = 0;
      end
    end
  endfunction

  // Build a frame with a correct checksum, low checksum byte first.
  function automatic void build_frame(input bit rand_fill, input logic [7:0] fill);
    logic [15:0] crc;
    int i;
    frame_bytes[0] = SYNC_FIRST;
    frame_bytes[1] = SYNC_SECOND;
    for (i = PAYLOAD_OFS; i < FRAME_LEN - 2; i++)
      frame_bytes[i] = rand_fill ? 8'($urandom_range(0, 255)) : fill;
    crc = CRC_INIT;
    for (i = 0; i < FRAME_LEN - 2; i++) crc = crc16_step(crc, frame_bytes[i]);
    frame_bytes[FRAME_LEN-2] = crc[7:0];
    frame_bytes[FRAME_LEN-1] = crc[15:8];
  endfunction

  function automatic logic [7:0] not_sync();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    return (v == SYNC_FIRST) ? 8'd118 : v;
  endfunction

  // Offer one byte in bursts with random gaps; predict once it is taken.
  task automatic send_byte(input logic [7:0] b);
    word_rec_t rec;
    int gap;
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    byte_valid <= 1'b1;
    rx_byte    <= b;
    do @(posedge clk); while (!byte_ready);
    burst_left--;
    bytes_sent++;
    absorb_byte(b);
    while (fresh_words.size() != 0) begin
      rec = fresh_words.pop_front();
      if (typed_on) rec.data = typed_word;
      pending_words.push_back(rec);
    end
  endtask

  task automatic send_range(input int lo, input int hi);
    int i;
    for (i = lo; i <= hi; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic run_row(input row_t r);
    int i;
    if (r.drain) begin
      // hold the byte channel until every payload word has come out
      byte_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clk);
      repeat (150) @(posedge clk);
      burst_left = 0;
    end
    if (r.hold) hold_reqs++;
    typed_on   = r.typed;
    typed_word = r.word;
    case (r.kind)
      ROW_BYTE: begin
        send_byte(r.val);
      end
      ROW_NOISE: begin
        for (i = 0; i < r.pos; i++) send_byte(8'($urandom_range(0, 255)));
      end
      ROW_GOOD: begin
        build_frame(r.rand_fill, r.val);
        send_range(0, FRAME_LEN - 1);
      end
      ROW_CORRUPT: begin
        build_frame(r.rand_fill, r.val);
        i = $urandom_range(PAYLOAD_OFS, FRAME_LEN - 1);
        frame_bytes[i] = frame_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
        send_range(0, FRAME_LEN - 1);
      end
      ROW_RESYNC: begin
        // junk frame whose later sync pair starts a good frame at pos
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (i = 2; i < r.pos; i++) send_byte(not_sync());
        build_frame(1'b1, 8'h00);
        send_range(0, FRAME_LEN - 1);
      end
      ROW_TAIL: begin
        // bad frame ending in a lone sync byte, then the rest of a good frame
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (i = 2; i < FRAME_LEN - 1; i++) send_byte(not_sync());
        send_byte(SYNC_FIRST);
        build_frame(1'b1, 8'h00);
        send_range(1, FRAME_LEN - 1);
      end
      default: ;
    endcase
    typed_on = 1'b0;
  endtask

  // Receiver: a pacing pattern of its own, and a long hold-off on request.
  initial begin
    int          hold_left;
    int          pace_left;
    int unsigned hold_seen;
    rx_pace_e    pace;
    hold_left = 0;
    pace_left = 0;
    hold_seen = 0;
    pace      = PACE_FREE;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_ready <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace      = rx_pace_e'($urandom_range(0, 2));
          pace_left = $urandom_range(20, 300);
        end
        pace_left--;
        case (pace)
          PACE_FREE:   word_ready <= 1'b1;
          PACE_HALF:   word_ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: word_ready <= ($urandom_range(0, 3) == 0);
          default:     word_ready <= 1'b1;
        endcase
      end
    end
  end

  // Compare each taken payload word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && word_valid && word_ready) begin
      got_word = '{word_index, payload_word, last_word};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: idx %0d data %08h last %0b",
                   got_word.idx, got_word.data, got_word.last);
      end else begin
        want_word = pending_words.pop_front();
        if (got_word !== want_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: want %0d %08h %0b, got %0d %08h %0b",
                     want_word.idx, want_word.data, want_word.last,
                     got_word.idx, got_word.data, got_word.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t        r;
    int unsigned bytes_from;
    int          sel, n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIRECTED; n++) run_row(DIRECTED[n]);

    // well-formed frames, most with random content, plus broken frames, noise and single bytes
    bytes_from = bytes_sent;
    while (bytes_sent - bytes_from < RANDOM_BYTES) begin
      r = '0;
      sel = $urandom_range(0, 15);
      if (sel <= 6) begin
        r.kind      = ROW_GOOD;
        r.rand_fill = (sel != 0);
        r.val       = 8'($urandom_range(0, 255));
      end else if (sel <= 8) begin
        r.kind      = ROW_CORRUPT;
        r.rand_fill = 1'b1;
      end else if (sel <= 10) begin
        r.kind = ROW_RESYNC;
        r.pos  = 7'($urandom_range(2, FRAME_LEN - 2));
      end else if (sel == 11) begin
        r.kind = ROW_TAIL;
      end else if (sel <= 13) begin
        r.kind = ROW_NOISE;
        r.pos  = 7'($urandom_range(1, 12));
      end else begin
        r.kind = ROW_BYTE;
        r.val  = (sel == 15) ? SYNC_FIRST : 8'($urandom_range(0, 255));
      end
      r.drain = ($urandom_range(0, 9) == 0);
      r.hold  = ($urandom_range(0, 19) == 0);
      run_row(r);
    end

    byte_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
